FILE: hw/rtl/assert_macros.svh
// Assertion helpers; the enclosing scope supplies clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/lpm_pkg.sv
package lpm_pkg;

  localparam int DEF_TABLE_ENTRIES = 32;
  localparam int PORT_COUNT        = 16;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } lpm_op_t;

  typedef struct packed {
    lpm_op_t     operation;
    logic [4:0]  slot;
    logic        entry_valid;
    logic [31:0] entry_dest;
    logic [31:0] entry_mask;
    logic [31:0] entry_gateway;
    logic [3:0]  entry_port;
    logic [31:0] lookup_address;
  } lpm_req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] hop_addr;
    logic [3:0]  out_port;
    logic [4:0]  matched_slot;
  } lpm_rsp_t;

  // Beat handed from cell to cell: the request plus the best route so far.
  typedef struct packed {
    lpm_req_t    req;
    logic        found;
    logic [31:0] best_mask;
    logic [31:0] best_gateway;
    logic [3:0]  best_port;
    logic [4:0]  best_slot;
  } lpm_beat_t;

endpackage

FILE: hw/rtl/lpm_chan_if.sv
interface lpm_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/ipv4_longest_prefix_route_lookup_top.sv
// Path: an accepted request beat passes one register per route cell and then the
// output register, which holds the lookup result; the first register is loaded at
// the accept edge. Throughput: one beat per cycle; the whole row stalls while a result
// waits at the output. Writes travel the same row and give no result, in order.
// Reset: synchronous rst clears every route's active bit, empties the row, holds ready low.
`include "assert_macros.svh"

module ipv4_longest_prefix_route_lookup_top #(
  parameter int TABLE_ENTRIES = lpm_pkg::DEF_TABLE_ENTRIES
) (
  input logic       clk,
  input logic       rst,
  lpm_chan_if.sink   req,
  lpm_chan_if.source rsp
);
  import lpm_pkg::*;

  logic      advance;
  logic      vld  [TABLE_ENTRIES+1];
  lpm_beat_t beat [TABLE_ENTRIES+1];

  logic      tail_lookup;
  logic      rsp_miss;
  logic      rsp_hit;
  logic      miss_fields_zero;
  logic      slot_ok;
  logic      port_ok;

  assign advance   = !rsp.valid || rsp.ready;
  assign req.ready = advance && !rst;

  // Drop writes that name a port beyond the interfaces.
  assign vld[0]  = req.valid && ((req.data.operation == OP_LOOKUP) ||
                                 (32'(req.data.entry_port) < PORT_COUNT));
  assign beat[0] = '{req: req.data, default: '0};

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    lpm_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .vld_in  (vld[i]),
      .beat_in (beat[i]),
      .vld_out (vld[i+1]),
      .beat_out(beat[i+1])
    );
  end

  lpm_result u_result (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .vld_in   (vld[TABLE_ENTRIES]),
    .beat_in  (beat[TABLE_ENTRIES]),
    .rsp_valid(rsp.valid),
    .rsp_data (rsp.data)
  );

  assign tail_lookup      = advance && vld[TABLE_ENTRIES] &&
                            (beat[TABLE_ENTRIES].req.operation == OP_LOOKUP);
  assign rsp_miss         = rsp.valid && !rsp.data.hit;
  assign rsp_hit          = rsp.valid && rsp.data.hit;
  assign miss_fields_zero = (rsp.data.hop_addr == 32'd0) && (rsp.data.out_port == 4'd0) &&
                            (rsp.data.matched_slot == 5'd0);
  assign slot_ok          = 32'(rsp.data.matched_slot) < TABLE_ENTRIES;
  assign port_ok          = 32'(rsp.data.out_port) < PORT_COUNT;

  `ASSERT_CLK(a_tail_lookup_emits, tail_lookup |=> rsp.valid, "lookup at row end gave no result")
  `ASSERT_ALWAYS(a_miss_zero, rsp_miss |-> miss_fields_zero, "miss result not all zero")
  `ASSERT_CLK(a_hit_slot_range, rsp_hit |-> slot_ok, "matched slot beyond table")
  `ASSERT_CLK(a_hit_port_range, rsp_hit |-> port_ok, "out port beyond interfaces")

endmodule

FILE: hw/rtl/lpm_cell.sv
module lpm_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              vld_in,
  input  lpm_pkg::lpm_beat_t beat_in,
  output logic              vld_out,
  output lpm_pkg::lpm_beat_t beat_out
);
  import lpm_pkg::*;

  logic        active;
  logic [31:0] dest;
  logic [31:0] mask;
  logic [31:0] gateway;
  logic [3:0]  port;

  logic      sel_write;
  logic      match;
  logic      better;
  lpm_beat_t beat_next;

  always_comb begin
    sel_write = vld_in && (beat_in.req.operation == OP_WRITE) &&
                (32'(beat_in.req.slot) == 32'(CELL_INDEX));
    match     = active && ((beat_in.req.lookup_address & mask) == (dest & mask));
    better    = vld_in && (beat_in.req.operation == OP_LOOKUP) && match &&
                (!beat_in.found || (mask > beat_in.best_mask));
    beat_next = beat_in;
    if (better) begin
      beat_next.found        = 1'b1;
      beat_next.best_mask    = mask;
      beat_next.best_gateway = gateway;
      beat_next.best_port    = port;
      beat_next.best_slot    = 5'(CELL_INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      vld_out <= 1'b0;
    end else if (advance) begin
      vld_out <= vld_in;
      if (sel_write) begin
        active <= beat_in.req.entry_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      beat_out <= beat_next;
      if (sel_write) begin
        dest    <= beat_in.req.entry_dest;
        mask    <= beat_in.req.entry_mask;
        gateway <= beat_in.req.entry_gateway;
        port    <= beat_in.req.entry_port;
      end
    end
  end

endmodule

FILE: hw/rtl/lpm_result.sv
module lpm_result (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               vld_in,
  input  lpm_pkg::lpm_beat_t beat_in,
  output logic               rsp_valid,
  output lpm_pkg::lpm_rsp_t  rsp_data
);
  import lpm_pkg::*;

  lpm_rsp_t rsp_next;

  always_comb begin
    rsp_next = '0;
    if (beat_in.found) begin
      rsp_next.hit          = 1'b1;
      rsp_next.hop_addr     = (beat_in.best_gateway != 32'd0) ? beat_in.best_gateway
                                                               : beat_in.req.lookup_address;
      rsp_next.out_port     = beat_in.best_port;
      rsp_next.matched_slot = beat_in.best_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= vld_in && (beat_in.req.operation == OP_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_data <= rsp_next;
    end
  end

endmodule
